### design/lmrs_pkg.sv
// Shared types, constants and glyph helpers for the LED matrix row scanner.
// No dependencies; used by the core and the frame buffer modules of the block.
package lmrs_pkg;

  // Matrix geometry
  localparam int unsigned ROWS       = 7;
  localparam int unsigned CHARS      = 5;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned COLS       = GLYPH_COLS * CHARS;
  localparam int unsigned FRAME_W    = ROWS * COLS;
  localparam int unsigned ROW_CNT_W  = $clog2(ROWS + 1);
  localparam int unsigned USED_ROWS  = (GLYPH_ROWS < ROWS) ? GLYPH_ROWS : ROWS;
  localparam int unsigned NUM_BANKS  = 2;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned GLYPH_W    = GLYPH_COLS * GLYPH_ROWS;
  localparam int unsigned DELAY_W    = 16;

  localparam logic [GLYPH_COLS-1:0] CHAR_MASK = '1;

  // Register reset values
  localparam logic              RST_CURSOR_EN  = 1'b0;
  localparam logic [DELAY_W-1:0] RST_BLINK_DELAY = 16'd500;
  localparam logic [WORD_W-1:0]  RST_ROW_DWELL  = 32'd200000;
  localparam logic [WORD_W-1:0]  RST_FRAME_GAP  = 32'd60000;
  localparam logic [2:0]         NO_CURSOR      = 3'd7;

  typedef enum logic [1:0] {
    REG_CURSOR_EN   = 2'd0,
    REG_BLINK_DELAY = 2'd1,
    REG_ROW_DWELL   = 2'd2,
    REG_FRAME_GAP   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_SCAN    = 3'd0,
    CMD_MS_TICK = 3'd1,
    CMD_GLYPH   = 3'd2,
    CMD_PRESENT = 3'd3,
    CMD_CURSOR  = 3'd4
  } cmd_e;

  typedef enum logic {
    ACT_DRIVE_ROW = 1'b0,
    ACT_RESTART   = 1'b1
  } row_act_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [GLYPH_W-1:0] glyph_bits;
    logic [2:0]         position;
  } in_item_t;

  typedef struct packed {
    logic              row_action;
    logic [2:0]        row_number;
    logic [WORD_W-1:0] column_word;
    logic [WORD_W-1:0] next_interval;
  } out_item_t;

  // Frame buffer control from the pipeline
  typedef struct packed {
    logic rd_en;     // stage 0 read issue
    logic rd_bank;
    logic clr_en;    // swap: drop contents of the new back bank
    logic clr_bank;
    logic wr_en;     // stage 1 glyph write-back
    logic s1_bank;   // bank of the item in stage 1
    logic adv;       // stage 1 moves on this cycle
  } fb_ctl_t;

  // Spread a 5x7 font entry over the frame image at a character position.
  function automatic logic [FRAME_W-1:0] place_glyph(logic [GLYPH_W-1:0] glyph,
                                                      logic [2:0] pos);
    logic [FRAME_W-1:0] f;
    f = '0;
    for (int p = 0; p < CHARS; p++) begin
      if (pos == 3'(p)) begin
        for (int c = 0; c < GLYPH_COLS; c++) begin
          for (int r = 0; r < USED_ROWS; r++) begin
            f[(ROWS - 1 - r) * COLS + (GLYPH_COLS - 1 - c) + GLYPH_COLS * p] =
              glyph[GLYPH_ROWS * c + r];
          end
        end
      end
    end
    return f;
  endfunction

  // Column mask of one character; positions past the last char give zero.
  function automatic logic [COLS-1:0] char_cols(logic [2:0] pos);
    logic [COLS-1:0] m;
    m = '0;
    for (int p = 0; p < CHARS; p++) begin
      if (pos == 3'(p)) begin
        m[GLYPH_COLS * p +: GLYPH_COLS] = CHAR_MASK;
      end
    end
    return m;
  endfunction

endpackage

### design/led_matrix_row_scanner_core.sv
// Top level of the LED matrix row scanner: command decode, scan/blink state,
// stage-1 pipeline and output register. Uses lmrs_pkg and lmrs_fbuf.
//
// Row scanner for a 7-row by 25-column multiplexed LED matrix showing five
// 5x7 characters. Commands arrive one per transfer: scan tick, millisecond
// tick, glyph write (ORs a font entry into the back buffer), present (swap
// at next frame restart, which also empties the new back buffer) and set
// cursor. Each scan tick yields one result: an active-low row word ORed with
// the cursor blink mask, or a frame-restart result carrying frame_gap. The
// block takes one command per cycle unless stalled; a scan tick's result is
// formed in stage 1 from the frame buffer RAM's registered read and then
// held in the output register. The input stalls only when a result is waiting
// in stage 1 behind a full output register that is not being drained. Both
// frame buffers live as two banks of one RAM word per bank; a swap just flips
// the bank pointer and drops the old front bank's valid bit, so there is no
// clearing pass after reset. Configuration is written through a plain write
// port by the user only while the block is idle; the block does not enforce it.
module led_matrix_row_scanner_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lmrs_pkg::in_item_t       in_data_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output lmrs_pkg::out_item_t      out_data_o,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [lmrs_pkg::WORD_W-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    OP_ROW,
    OP_RESTART,
    OP_GLYPH
  } op_e;

  // configuration registers
  logic                            cursor_en_q;
  logic [lmrs_pkg::DELAY_W-1:0]    blink_delay_q;
  logic [lmrs_pkg::WORD_W-1:0]     row_dwell_q;
  logic [lmrs_pkg::WORD_W-1:0]     frame_gap_q;

  // scan / blink state
  logic [lmrs_pkg::ROW_CNT_W-1:0]  scan_row_q, scan_row_d;
  logic                            swap_pending_q, swap_pending_d;
  logic                            front_bank_q, front_bank_d;
  logic [2:0]                      cursor_q, cursor_d;
  logic [lmrs_pkg::COLS-1:0]       blink_mask_q, blink_mask_d;
  logic [lmrs_pkg::WORD_W-1:0]     elapsed_q, elapsed_d;

  // stage 1
  logic                            s1_valid_q, s1_valid_d;
  op_e                             s1_op_q, s1_op_d;
  logic                            s1_bank_q, s1_bank_d;
  logic [lmrs_pkg::ROW_CNT_W-1:0]  s1_row_q, s1_row_d;
  logic [lmrs_pkg::FRAME_W-1:0]    s1_ins_q, s1_ins_d;
  logic [lmrs_pkg::COLS-1:0]       s1_mask_q, s1_mask_d;
  logic [lmrs_pkg::WORD_W-1:0]     s1_interval_q, s1_interval_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  lmrs_pkg::out_item_t             out_data_q, out_data_d;

  logic                            accept;
  logic                            s1_result;
  logic                            stall;
  logic                            out_load;
  logic                            clr_en;
  lmrs_pkg::fb_ctl_t               fb_ctl;
  logic                            rd_en;
  logic [lmrs_pkg::FRAME_W-1:0]    frame;
  logic [lmrs_pkg::COLS-1:0]       row_bits;

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 holds a result only while the output register is full
  // and not being drained; glyph write-backs never stall.
  // ---------------------------------------------------------------------------
  assign s1_result  = s1_valid_q && ((s1_op_q == OP_ROW) || (s1_op_q == OP_RESTART));
  assign stall      = s1_result && out_valid_q && !out_ready_i;
  assign in_ready_o = !stall;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = s1_result && !stall;

  // ---------------------------------------------------------------------------
  // Stage 0: command decode and all scalar state updates
  // ---------------------------------------------------------------------------
  always_comb begin
    scan_row_d     = scan_row_q;
    swap_pending_d = swap_pending_q;
    front_bank_d   = front_bank_q;
    cursor_d       = cursor_q;
    blink_mask_d   = blink_mask_q;
    elapsed_d      = elapsed_q;
    clr_en         = 1'b0;
    rd_en          = 1'b0;

    s1_valid_d     = stall ? s1_valid_q : 1'b0;
    s1_op_d        = s1_op_q;
    s1_bank_d      = s1_bank_q;
    s1_row_d       = s1_row_q;
    s1_ins_d       = s1_ins_q;
    s1_mask_d      = s1_mask_q;
    s1_interval_d  = s1_interval_q;

    if (accept) begin
      unique case (in_data_i.command)
        lmrs_pkg::CMD_SCAN: begin
          s1_valid_d = 1'b1;
          s1_row_d   = scan_row_q;
          s1_mask_d  = blink_mask_q;
          s1_bank_d  = front_bank_q;
          s1_ins_d   = '0;
          if (scan_row_q < lmrs_pkg::ROW_CNT_W'(lmrs_pkg::ROWS)) begin
            // drive the next row: fetch the front bank
            s1_op_d       = OP_ROW;
            s1_interval_d = row_dwell_q;
            rd_en         = 1'b1;
            scan_row_d    = scan_row_q + 1'b1;
          end else begin
            // frame restart: blink check, pending swap, rewind the row counter
            s1_op_d       = OP_RESTART;
            s1_interval_d = frame_gap_q;
            scan_row_d    = '0;
            if (elapsed_q > lmrs_pkg::WORD_W'(blink_delay_q)) begin
              elapsed_d = '0;
              if (cursor_en_q) begin
                blink_mask_d = blink_mask_q ^ lmrs_pkg::char_cols(cursor_q);
              end else begin
                blink_mask_d = '0;
              end
            end
            if (swap_pending_q) begin
              // old front becomes the (empty) back bank
              front_bank_d   = !front_bank_q;
              clr_en         = 1'b1;
              swap_pending_d = 1'b0;
            end
          end
        end
        lmrs_pkg::CMD_MS_TICK: begin
          if (elapsed_q != '1) begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end
        lmrs_pkg::CMD_GLYPH: begin
          if (in_data_i.position < 3'(lmrs_pkg::CHARS)) begin
            s1_valid_d = 1'b1;
            s1_op_d    = OP_GLYPH;
            s1_bank_d  = !front_bank_q;
            s1_ins_d   = lmrs_pkg::place_glyph(in_data_i.glyph_bits, in_data_i.position);
            rd_en      = 1'b1;
          end
        end
        lmrs_pkg::CMD_PRESENT: begin
          swap_pending_d = 1'b1;
        end
        lmrs_pkg::CMD_CURSOR: begin
          cursor_d     = in_data_i.position;
          blink_mask_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame buffer
  // ---------------------------------------------------------------------------
  always_comb begin
    fb_ctl.rd_en    = rd_en;
    fb_ctl.rd_bank  = (in_data_i.command == lmrs_pkg::CMD_GLYPH) ? !front_bank_q
                                                                 : front_bank_q;
    fb_ctl.clr_en   = clr_en;
    fb_ctl.clr_bank = front_bank_q;
    fb_ctl.wr_en    = s1_valid_q && (s1_op_q == OP_GLYPH);
    fb_ctl.s1_bank  = s1_bank_q;
    fb_ctl.adv      = !stall;
  end

  lmrs_fbuf u_fbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fb_ctl),
    .ins_i   (s1_ins_q),
    .frame_o (frame)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: form the result
  // ---------------------------------------------------------------------------
  assign row_bits = frame[s1_row_q * lmrs_pkg::COLS +: lmrs_pkg::COLS];

  always_comb begin
    out_data_d = out_data_q;
    if (out_load) begin
      if (s1_op_q == OP_ROW) begin
        out_data_d.row_action  = lmrs_pkg::ACT_DRIVE_ROW;
        out_data_d.row_number  = 3'(s1_row_q);
        out_data_d.column_word = {{(lmrs_pkg::WORD_W - lmrs_pkg::COLS){1'b1}}, ~row_bits}
                                 | lmrs_pkg::WORD_W'(s1_mask_q);
      end else begin
        out_data_d.row_action  = lmrs_pkg::ACT_RESTART;
        out_data_d.row_number  = '0;
        out_data_d.column_word = '0;
      end
      out_data_d.next_interval = s1_interval_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_en_q    <= lmrs_pkg::RST_CURSOR_EN;
      blink_delay_q  <= lmrs_pkg::RST_BLINK_DELAY;
      row_dwell_q    <= lmrs_pkg::RST_ROW_DWELL;
      frame_gap_q    <= lmrs_pkg::RST_FRAME_GAP;
      scan_row_q     <= '0;
      swap_pending_q <= 1'b0;
      front_bank_q   <= 1'b0;
      cursor_q       <= lmrs_pkg::NO_CURSOR;
      blink_mask_q   <= '0;
      elapsed_q      <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lmrs_pkg::REG_CURSOR_EN:   cursor_en_q   <= cfg_wdata_i[0];
          lmrs_pkg::REG_BLINK_DELAY: blink_delay_q <= cfg_wdata_i[lmrs_pkg::DELAY_W-1:0];
          lmrs_pkg::REG_ROW_DWELL:   row_dwell_q   <= cfg_wdata_i;
          lmrs_pkg::REG_FRAME_GAP:   frame_gap_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      scan_row_q     <= scan_row_d;
      swap_pending_q <= swap_pending_d;
      front_bank_q   <= front_bank_d;
      cursor_q       <= cursor_d;
      blink_mask_q   <= blink_mask_d;
      elapsed_q      <= elapsed_d;
      s1_valid_q     <= s1_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q       <= s1_op_d;
    s1_bank_q     <= s1_bank_d;
    s1_row_q      <= s1_row_d;
    s1_ins_q      <= s1_ins_d;
    s1_mask_q     <= s1_mask_d;
    s1_interval_q <= s1_interval_d;
    out_data_q    <= out_data_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A swap never empties the bank that a glyph write-back lands in.
  a_wr_clr_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_ctl.wr_en && fb_ctl.clr_en |-> fb_ctl.s1_bank != fb_ctl.clr_bank)
    else $error("glyph write-back and buffer clear hit the same bank");

  // Glyph write-backs only ever go to the back bank.
  a_wr_back_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_ctl.wr_en |-> s1_bank_q != front_bank_q)
    else $error("glyph write-back targets the front bank");

  // Input only stalls behind a full, undrained output register.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // Row counter never runs past the restart point.
  a_row_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_row_q <= lmrs_pkg::ROW_CNT_W'(lmrs_pkg::ROWS))
    else $error("scan row counter out of range");

endmodule

### design/lmrs_ram.sv
// Generic single-write, single-read RAM with registered (read-first) output.
// No dependencies.
module lmrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lmrs_fbuf.sv
// Double frame buffer: two banks in one RAM, per-bank valid bits and
// write-back forwarding for back-to-back read-modify-write. Uses lmrs_pkg, lmrs_ram.
module lmrs_fbuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lmrs_pkg::fb_ctl_t             ctl_i,
  input  logic [lmrs_pkg::FRAME_W-1:0]  ins_i,
  output logic [lmrs_pkg::FRAME_W-1:0]  frame_o
);

  logic [lmrs_pkg::FRAME_W-1:0]   rdata;
  logic [lmrs_pkg::FRAME_W-1:0]   wdata;
  logic [lmrs_pkg::NUM_BANKS-1:0] bank_valid_q, bank_valid_d;
  logic                           fwd_valid_q;
  logic                           fwd_bank_q;
  logic [lmrs_pkg::FRAME_W-1:0]   fwd_data_q;
  logic                           fwd_hit;

  lmrs_ram #(
    .WIDTH (lmrs_pkg::FRAME_W),
    .DEPTH (lmrs_pkg::NUM_BANKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (ctl_i.s1_bank),
    .wdata_i (wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i (ctl_i.rd_bank),
    .rdata_o (rdata)
  );

  // Previous item wrote the same bank at the edge our read was issued.
  assign fwd_hit = fwd_valid_q && (fwd_bank_q == ctl_i.s1_bank);

  always_comb begin
    if (fwd_hit) begin
      frame_o = fwd_data_q;
    end else if (bank_valid_q[ctl_i.s1_bank]) begin
      frame_o = rdata;
    end else begin
      frame_o = '0;
    end
  end

  assign wdata = frame_o | ins_i;

  always_comb begin
    bank_valid_d = bank_valid_q;
    if (ctl_i.clr_en) begin
      bank_valid_d[ctl_i.clr_bank] = 1'b0;
    end
    if (ctl_i.wr_en) begin
      bank_valid_d[ctl_i.s1_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_valid_q <= '0;
      fwd_valid_q  <= 1'b0;
    end else begin
      bank_valid_q <= bank_valid_d;
      if (ctl_i.adv) begin
        fwd_valid_q <= ctl_i.wr_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      fwd_bank_q <= ctl_i.s1_bank;
      fwd_data_q <= wdata;
    end
  end

endmodule
